// ===== rtl/core/ght_pkg.sv =====
// shared constants, codes and types of the generational handle table
`timescale 1ns / 1ps

package ght_pkg;

  // table size and handle layout
  localparam int unsigned SLOT_COUNT   = 1024;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned GEN_W        = 32;
  localparam int unsigned VALUE_W      = 31;
  localparam int unsigned HANDLE_W     = 64;
  localparam int unsigned OUT_HANDLE_W = 63;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned TAG_LSB      = 48;
  localparam logic [TAG_W-1:0] HANDLE_TAG = 16'h4656;
  localparam int unsigned PAD_W = OUT_HANDLE_W - (TAG_W - 1) - GEN_W - IDX_W;

  // valid marks are packed into rows of ROW_W bits
  localparam int unsigned ROW_W   = 32;
  localparam int unsigned ROW_LOG = 5;
  localparam int unsigned ROWF_W  = IDX_W - ROW_LOG;
  localparam int unsigned ROWS    = (SLOT_COUNT + ROW_W - 1) / ROW_W;
  localparam int unsigned ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SLOT_AW = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned ENTRY_W = GEN_W + VALUE_W;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_RELEASE = 2'd2
  } ght_op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_STALE = 2'd2
  } ght_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_ALLOC,
    ST_CHECK,
    ST_REPLY
  } ght_state_e;

  typedef struct packed {
    logic               found;
    logic [ROW_LOG-1:0] idx;
  } ght_pick_t;

endpackage

// ===== rtl/core/ght_if.sv =====
// request and response channel interfaces of the generational handle table
`timescale 1ns / 1ps

interface ght_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic signed [ght_pkg::HANDLE_W-1:0] handle_in;
  logic [ght_pkg::VALUE_W-1:0]         value_in;

  modport source (output valid, operation, handle_in, value_in, input ready);
  modport sink   (input valid, operation, handle_in, value_in, output ready);
endinterface

interface ght_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [ght_pkg::OUT_HANDLE_W-1:0] handle_out;
  logic [ght_pkg::VALUE_W-1:0]     value_out;

  modport source (output valid, status, handle_out, value_out, input ready);
  modport sink   (input valid, status, handle_out, value_out, output ready);
endinterface

// ===== rtl/core/generational_handle_table_core.sv =====
// top level of the generational handle table: control, slot memories, response register
`timescale 1ns / 1ps

// usage
// - req_i carries one request: operation (allocate, look up, release), a 64-bit
//   handle to check and a 31-bit value to store; rsp_o returns exactly one
//   response per request: status, issued handle and stored value
// - both channels use valid/ready; a request is taken at an edge with both high
// - requests are worked one at a time; ready is high whenever no request is
//   in progress, also while an earlier response still waits on rsp_o
// - look up, release, a full table and an unknown operation go from acceptance
//   to a single check or reply step that loads rsp_o; allocate goes through a
//   bit pick and then a generation read-modify-write, the row pick happens in the
//   accepting cycle; the slot and valid memories both have registered reads
// - a new request is taken only once the last one has loaded its response into
//   the response register, which waits while rsp_o is stalled
// - when rsp_o stalls, the finished request waits in its last step and the
//   memories are written only once the response register can take the result
// - reset clears the valid rows' full marks, the high-water mark and the
//   response valid flag; no clearing pass is needed: slots at or above the
//   high-water mark read as free with generation zero

module generational_handle_table_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  ght_req_if.sink          req_i,
  ght_rsp_if.source        rsp_o
);

  // state and control registers
  ght_pkg::ght_state_e state_q, state_d;
  logic [ght_pkg::ROWS-1:0]  row_full_q, row_full_d;
  logic [ght_pkg::CNT_W-1:0] hwm_q, hwm_d;

  // request payload and per-request working registers
  logic [1:0]                    op_q;
  logic [ght_pkg::HANDLE_W-1:0]  handle_q;
  logic [ght_pkg::VALUE_W-1:0]   value_q;
  logic [ght_pkg::ROWF_W-1:0]    alloc_row_q, alloc_row_d;
  logic [ght_pkg::IDX_W-1:0]     slot_q, slot_d;
  logic [ght_pkg::ROW_W-1:0]     word_q, word_d;
  logic                          row_fill_q, row_fill_d;
  ght_pkg::ght_status_e          reply_status_q, reply_status_d;

  // response register
  logic                              rsp_valid_q;
  ght_pkg::ght_status_e              rsp_status_q, rsp_status_d;
  logic [ght_pkg::OUT_HANDLE_W-1:0]  rsp_handle_q, rsp_handle_d;
  logic [ght_pkg::VALUE_W-1:0]       rsp_value_q, rsp_value_d;
  logic                              rsp_load;
  logic                              rsp_free;

  // memories: valid marks by row, {generation, value} by slot
  logic [ght_pkg::ROW_W-1:0]   valid_mem [ght_pkg::ROWS];
  logic [ght_pkg::ROW_W-1:0]   valid_rdata_q;
  logic                        valid_re, valid_we;
  logic [ght_pkg::ROW_AW-1:0]  valid_raddr, valid_waddr;
  logic [ght_pkg::ROW_W-1:0]   valid_wdata;

  logic [ght_pkg::ENTRY_W-1:0] data_mem [ght_pkg::SLOT_COUNT];
  logic [ght_pkg::ENTRY_W-1:0] data_rdata_q;
  logic                        data_re, data_we;
  logic [ght_pkg::SLOT_AW-1:0] data_raddr, data_waddr;
  logic [ght_pkg::ENTRY_W-1:0] data_wdata;

  // datapath signals
  logic                        req_fire;
  logic [ght_pkg::ROW_W-1:0]   row_used;
  ght_pkg::ght_pick_t          row_pick;
  ght_pkg::ght_pick_t          bit_pick;
  logic [ght_pkg::ROWF_W-1:0]  row_sel;
  logic [ght_pkg::ROW_W-1:0]   word_live;
  logic [ght_pkg::ROW_W-1:0]   word_occ;
  logic [ght_pkg::IDX_W-1:0]   h_idx;
  logic [ght_pkg::GEN_W-1:0]   h_gen;
  logic                        h_pass;
  logic [ght_pkg::GEN_W-1:0]   gen_old, gen_inc, gen_new;
  logic [ght_pkg::IDX_W-1:0]   pick_slot;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  // row-level free search; rows past the table count as full
  always_comb begin
    for (int r = 0; r < ght_pkg::ROW_W; r++) begin
      row_used[r] = (r < ght_pkg::ROWS) ? row_full_q[ght_pkg::ROW_AW'(r)] : 1'b1;
    end
  end

  ght_pick u_row_pick (
    .used_i (row_used),
    .pick_o (row_pick)
  );

  // live valid marks of the row just read; slots at or above the
  // high-water mark were never allocated and count as free
  assign row_sel = (state_q == ght_pkg::ST_PICK) ? alloc_row_q
                                                 : handle_q[ght_pkg::IDX_W-1:ght_pkg::ROW_LOG];

  always_comb begin
    logic [ght_pkg::IDX_W-1:0] num;
    num = '0;
    for (int b = 0; b < ght_pkg::ROW_W; b++) begin
      num          = {row_sel, ght_pkg::ROW_LOG'(b)};
      word_live[b] = valid_rdata_q[b] && ({1'b0, num} < hwm_q);
      word_occ[b]  = word_live[b] ||
                     ({1'b0, num} >= ght_pkg::CNT_W'(ght_pkg::SLOT_COUNT));
    end
  end

  ght_pick u_bit_pick (
    .used_i (word_occ),
    .pick_o (bit_pick)
  );

  assign pick_slot = {alloc_row_q, bit_pick.idx};

  // handle check against the slot read back
  assign h_idx  = handle_q[ght_pkg::IDX_W-1:0];
  assign h_gen  = handle_q[ght_pkg::IDX_W+ght_pkg::GEN_W-1:ght_pkg::IDX_W];
  assign h_pass = (handle_q[ght_pkg::HANDLE_W-1:ght_pkg::TAG_LSB] == ght_pkg::HANDLE_TAG) &&
                  ({1'b0, h_idx} < ght_pkg::CNT_W'(ght_pkg::SLOT_COUNT)) &&
                  word_live[h_idx[ght_pkg::ROW_LOG-1:0]] &&
                  (data_rdata_q[ght_pkg::ENTRY_W-1:ght_pkg::VALUE_W] == h_gen);

  // next generation, zero skipped; never-allocated slots start at zero
  assign gen_old = ({1'b0, slot_q} >= hwm_q) ? '0
                   : data_rdata_q[ght_pkg::ENTRY_W-1:ght_pkg::VALUE_W];
  assign gen_inc = gen_old + ght_pkg::GEN_W'(1);
  assign gen_new = (gen_inc == '0) ? ght_pkg::GEN_W'(1) : gen_inc;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ght_pkg::ST_IDLE: begin
        if (req_fire) begin
          priority case (req_i.operation)
            ght_pkg::OP_ALLOC:   state_d = row_pick.found ? ght_pkg::ST_PICK
                                                          : ght_pkg::ST_REPLY;
            ght_pkg::OP_LOOKUP,
            ght_pkg::OP_RELEASE: state_d = ght_pkg::ST_CHECK;
            default:             state_d = ght_pkg::ST_REPLY;
          endcase
        end
      end
      ght_pkg::ST_PICK:  state_d = ght_pkg::ST_ALLOC;
      ght_pkg::ST_ALLOC,
      ght_pkg::ST_CHECK,
      ght_pkg::ST_REPLY: begin
        if (rsp_free) begin
          state_d = ght_pkg::ST_IDLE;
        end
      end
      default: state_d = ght_pkg::ST_IDLE;
    endcase
  end

  // outputs of each step: memory ports, bookkeeping, response
  always_comb begin
    req_i.ready    = 1'b0;
    valid_re       = 1'b0;
    valid_raddr    = '0;
    data_re        = 1'b0;
    data_raddr     = '0;
    valid_we       = 1'b0;
    valid_waddr    = '0;
    valid_wdata    = '0;
    data_we        = 1'b0;
    data_waddr     = '0;
    data_wdata     = '0;
    row_full_d     = row_full_q;
    hwm_d          = hwm_q;
    alloc_row_d    = alloc_row_q;
    slot_d         = slot_q;
    word_d         = word_q;
    row_fill_d     = row_fill_q;
    reply_status_d = reply_status_q;
    rsp_load       = 1'b0;
    rsp_status_d   = ght_pkg::STATUS_STALE;
    rsp_handle_d   = '0;
    rsp_value_d    = '0;

    unique case (state_q)
      ght_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        alloc_row_d = ght_pkg::ROWF_W'(row_pick.idx);
        reply_status_d = (req_i.operation == ght_pkg::OP_ALLOC) ? ght_pkg::STATUS_FULL
                                                                : ght_pkg::STATUS_STALE;
        // allocate reads the first non-full row, check reads the handle's row and slot
        valid_re   = req_fire;
        data_re    = req_fire;
        data_raddr = req_i.handle_in[ght_pkg::SLOT_AW-1:0];
        if (req_i.operation == ght_pkg::OP_ALLOC) begin
          valid_raddr = row_pick.idx[ght_pkg::ROW_AW-1:0];
        end else begin
          valid_raddr = req_i.handle_in[ght_pkg::ROW_LOG+ght_pkg::ROW_AW-1:ght_pkg::ROW_LOG];
        end
      end
      ght_pkg::ST_PICK: begin
        slot_d     = pick_slot;
        word_d     = word_live | (ght_pkg::ROW_W'(1) << bit_pick.idx);
        row_fill_d = &(word_occ | (ght_pkg::ROW_W'(1) << bit_pick.idx));
        data_re    = 1'b1;
        data_raddr = pick_slot[ght_pkg::SLOT_AW-1:0];
      end
      ght_pkg::ST_ALLOC: begin
        if (rsp_free) begin
          data_we     = 1'b1;
          data_waddr  = slot_q[ght_pkg::SLOT_AW-1:0];
          data_wdata  = {gen_new, value_q};
          valid_we    = 1'b1;
          valid_waddr = slot_q[ght_pkg::ROW_LOG+ght_pkg::ROW_AW-1:ght_pkg::ROW_LOG];
          valid_wdata = word_q;
          row_full_d[valid_waddr] = row_fill_q;
          if ({1'b0, slot_q} == hwm_q) begin
            hwm_d = hwm_q + ght_pkg::CNT_W'(1);
          end
          rsp_load     = 1'b1;
          rsp_status_d = ght_pkg::STATUS_OK;
          rsp_handle_d = {ght_pkg::HANDLE_TAG[ght_pkg::TAG_W-2:0], ght_pkg::PAD_W'(0),
                          gen_new, slot_q};
        end
      end
      ght_pkg::ST_CHECK: begin
        if (rsp_free) begin
          rsp_load = 1'b1;
          if (h_pass) begin
            rsp_status_d = ght_pkg::STATUS_OK;
            rsp_value_d  = data_rdata_q[ght_pkg::VALUE_W-1:0];
            // release clears the mark and reopens the row
            if (op_q == ght_pkg::OP_RELEASE) begin
              valid_we    = 1'b1;
              valid_waddr = h_idx[ght_pkg::ROW_LOG+ght_pkg::ROW_AW-1:ght_pkg::ROW_LOG];
              valid_wdata = word_live & ~(ght_pkg::ROW_W'(1) << h_idx[ght_pkg::ROW_LOG-1:0]);
              row_full_d[valid_waddr] = 1'b0;
            end
          end
        end
      end
      ght_pkg::ST_REPLY: begin
        if (rsp_free) begin
          rsp_load     = 1'b1;
          rsp_status_d = reply_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ght_pkg::ST_IDLE;
      row_full_q  <= '0;
      hwm_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_full_q <= row_full_d;
      hwm_q      <= hwm_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q     <= req_i.operation;
      handle_q <= req_i.handle_in;
      value_q  <= req_i.value_in;
    end
    alloc_row_q    <= alloc_row_d;
    slot_q         <= slot_d;
    word_q         <= word_d;
    row_fill_q     <= row_fill_d;
    reply_status_q <= reply_status_d;
    if (rsp_load) begin
      rsp_status_q <= rsp_status_d;
      rsp_handle_q <= rsp_handle_d;
      rsp_value_q  <= rsp_value_d;
    end
  end

  // valid mark memory
  always_ff @(posedge clk_i) begin
    if (valid_we) begin
      valid_mem[valid_waddr] <= valid_wdata;
    end
    if (valid_re) begin
      valid_rdata_q <= valid_mem[valid_raddr];
    end
  end

  // generation and value memory
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (data_re) begin
      data_rdata_q <= data_mem[data_raddr];
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.handle_out = rsp_handle_q;
  assign rsp_o.value_out  = rsp_value_q;

  // an issued generation is never zero
  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_we |-> (data_wdata[ght_pkg::ENTRY_W-1:ght_pkg::VALUE_W] != '0))
    else $error("zero generation written");

  // full is reported only when every row is marked full
  a_full_all_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_load && (rsp_status_d == ght_pkg::STATUS_FULL)) |-> (&row_used))
    else $error("table full reported with a free row");

  // the high-water mark only ever grows by one slot
  a_hwm_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hwm_q != $past(hwm_q)) |-> (hwm_q == $past(hwm_q) + ght_pkg::CNT_W'(1)))
    else $error("high-water mark jumped");

  // a release frees exactly one slot of its row
  a_release_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_we && (state_q == ght_pkg::ST_CHECK)) |->
      ($countones(valid_wdata) + 1 == $countones(word_live)))
    else $error("release changed more than one valid mark");

endmodule

// ===== rtl/core/ght_pick.sv =====
// lowest-clear-bit priority encoder over one row of occupancy bits
`timescale 1ns / 1ps

module ght_pick (
  input  logic [ght_pkg::ROW_W-1:0] used_i,
  output ght_pkg::ght_pick_t        pick_o
);

  always_comb begin
    pick_o = '0;
    for (int b = ght_pkg::ROW_W - 1; b >= 0; b--) begin
      if (!used_i[b]) begin
        pick_o.found = 1'b1;
        pick_o.idx   = ght_pkg::ROW_LOG'(b);
      end
    end
  end

endmodule
